/* rtl/core/lzot_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lzot_pkg
// Shared constants, codes and control types of the layer z-order table.
// ----------------------------------------------------------------------------
package lzot_pkg;

  localparam int MAX_LAYERS = 16;
  localparam int CNT_W      = $clog2(MAX_LAYERS + 1);
  localparam int IDX_W      = $clog2(MAX_LAYERS);
  localparam int ID_W       = 5;
  localparam int POS_W      = 16;
  localparam int REQ_W      = 3;
  localparam int HGT_W      = 6;
  localparam int ST_W       = 2;
  localparam int CMP_W      = ID_W + CNT_W;

  localparam logic [REQ_W-1:0] REQ_NEW        = 3'd0;
  localparam logic [REQ_W-1:0] REQ_MOVE_ABS   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_MOVE_REL   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_SET_HEIGHT = 3'd3;
  localparam logic [REQ_W-1:0] REQ_HIDE       = 3'd4;
  localparam logic [REQ_W-1:0] REQ_LIST       = 3'd5;

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_UNKNOWN = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POS,
    S_FIND,
    S_REMOVE,
    S_INSERT,
    S_LIST,
    S_RESP
  } state_t;

  typedef enum logic [1:0] {
    POS_NONE,
    POS_ZERO,
    POS_LOAD,
    POS_ADD
  } pos_op_t;

  typedef struct packed {
    logic [IDX_W-1:0] rd_idx;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [ID_W-1:0]  wr_id;
    logic [ID_W-1:0]  cmp_id;
  } stack_ctl_t;

  typedef struct packed {
    pos_op_t                  op;
    logic [IDX_W-1:0]         addr;
    logic signed [POS_W-1:0]  dx;
    logic signed [POS_W-1:0]  dy;
  } pos_ctl_t;

endpackage
`default_nettype wire

/* rtl/core/lzot_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lzot_if
// Request and result channels: valid/ready handshake plus payload.
// ----------------------------------------------------------------------------
interface lzot_in_if;
  import lzot_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [REQ_W-1:0]        req_type;
  logic [ID_W-1:0]         layer_id;
  logic signed [HGT_W-1:0] height;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;

  modport source (output valid, req_type, layer_id, height, pos_x, pos_y,
                  input ready);
  modport sink (input valid, req_type, layer_id, height, pos_x, pos_y,
                output ready);
endinterface

interface lzot_out_if;
  import lzot_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [ST_W-1:0]         status;
  logic [ID_W-1:0]         out_layer_id;
  logic signed [POS_W-1:0] out_x;
  logic signed [POS_W-1:0] out_y;
  logic [ID_W-1:0]         stack_index;
  logic                    last;

  modport source (output valid, status, out_layer_id, out_x, out_y, stack_index, last,
                  input ready);
  modport sink (input valid, status, out_layer_id, out_x, out_y, stack_index, last,
                output ready);
endinterface
`default_nettype wire

/* rtl/core/lzot_stack.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lzot_stack
// Z-order stack entries with one read port, one write port and the id compare.
// ----------------------------------------------------------------------------
module lzot_stack (
  input  wire                       clk,
  input  lzot_pkg::stack_ctl_t      ctl,
  output logic [lzot_pkg::ID_W-1:0] rd_id,
  output logic                      hit
);
  import lzot_pkg::*;

  logic [ID_W-1:0] entry_r [MAX_LAYERS];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      entry_r[ctl.wr_idx] <= ctl.wr_id;
    end
  end

  assign rd_id = entry_r[ctl.rd_idx];
  assign hit   = (rd_id == ctl.cmp_id);

endmodule
`default_nettype wire

/* rtl/core/lzot_pos.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lzot_pos
// Per-layer x/y position store with the shared wrap-around x/y adders.
// ----------------------------------------------------------------------------
module lzot_pos (
  input  wire                               clk,
  input  lzot_pkg::pos_ctl_t                ctl,
  output logic signed [lzot_pkg::POS_W-1:0] rd_x,
  output logic signed [lzot_pkg::POS_W-1:0] rd_y
);
  import lzot_pkg::*;

  logic signed [POS_W-1:0] x_r [MAX_LAYERS];
  logic signed [POS_W-1:0] y_r [MAX_LAYERS];
  logic signed [POS_W-1:0] sum_x;
  logic signed [POS_W-1:0] sum_y;

  assign rd_x  = x_r[ctl.addr];
  assign rd_y  = y_r[ctl.addr];
  assign sum_x = rd_x + ctl.dx;
  assign sum_y = rd_y + ctl.dy;

  always_ff @(posedge clk) begin
    case (ctl.op)
      POS_ZERO: begin
        x_r[ctl.addr] <= '0;
        y_r[ctl.addr] <= '0;
      end
      POS_LOAD: begin
        x_r[ctl.addr] <= ctl.dx;
        y_r[ctl.addr] <= ctl.dy;
      end
      POS_ADD: begin
        x_r[ctl.addr] <= sum_x;
        y_r[ctl.addr] <= sum_y;
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

/* rtl/core/layer_z_order_table_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// layer_z_order_table_core
// Compositor layer table and z-order stack, run by a small sequencer.
// ----------------------------------------------------------------------------
// One request is taken at a time; in_ch.ready is high only while the
// sequencer is idle. New layer and move requests go through S_POS and then
// S_RESP to a loaded result word; rejected requests, spare codes and an
// empty listing go straight to S_RESP. Hide and set height walk the stack
// through its single read port, one entry per cycle: a search, then a
// removal shift, and for set height an insertion shift (S_FIND, S_REMOVE,
// S_INSERT). A listing emits one word per cycle while the sink takes them,
// count words in all. A result word sits in an output register, so a
// stalled sink costs cycles only when a new word is due.
module layer_z_order_table_core (
  input wire         clk,
  input wire         rst_n,
  lzot_in_if.sink    in_ch,
  lzot_out_if.source out_ch
);
  import lzot_pkg::*;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] made_r, made_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] h_r, h_nxt;
  logic [ID_W-1:0]  id_r, id_nxt;
  logic             hide_r, hide_nxt;
  logic [IDX_W-1:0] slot_r, slot_nxt;
  pos_op_t          pos_op_r, pos_op_nxt;
  logic signed [POS_W-1:0] px_r, px_nxt;
  logic signed [POS_W-1:0] py_r, py_nxt;
  logic [ST_W-1:0]  res_status_r, res_status_nxt;
  logic [ID_W-1:0]  res_id_r, res_id_nxt;
  logic             res_zero_r, res_zero_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic [ST_W-1:0]         out_status_r, out_status_nxt;
  logic [ID_W-1:0]         out_id_r, out_id_nxt;
  logic signed [POS_W-1:0] out_x_r, out_x_nxt;
  logic signed [POS_W-1:0] out_y_r, out_y_nxt;
  logic [ID_W-1:0]         out_idx_r, out_idx_nxt;
  logic                    out_last_r, out_last_nxt;

  stack_ctl_t              stk_ctl;
  pos_ctl_t                pos_ctl;
  logic [ID_W-1:0]         stk_rd_id;
  logic                    stk_hit;
  logic signed [POS_W-1:0] pos_rd_x;
  logic signed [POS_W-1:0] pos_rd_y;

  logic             in_fire;
  logic             slot_free;
  logic             out_load;
  logic             id_bad;
  logic             made_full;
  logic             count_full;
  logic [CNT_W-1:0] h_clamp;
  logic [ID_W-1:0]  h_raw;
  logic [CNT_W-1:0] idx_inc;
  logic [CNT_W-1:0] idx_dec;
  logic [ID_W-1:0]  lid_m1;
  logic             list_last;

  lzot_stack u_stack (
    .clk   (clk),
    .ctl   (stk_ctl),
    .rd_id (stk_rd_id),
    .hit   (stk_hit)
  );

  lzot_pos u_pos (
    .clk  (clk),
    .ctl  (pos_ctl),
    .rd_x (pos_rd_x),
    .rd_y (pos_rd_y)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid & in_ch.ready;
  assign slot_free   = ~out_valid_r | out_ch.ready;

  assign id_bad = (in_ch.layer_id == '0) ||
                  (CMP_W'(in_ch.layer_id) > CMP_W'(made_r));
  assign made_full  = (made_r == CNT_W'(MAX_LAYERS));
  assign count_full = (count_r == CNT_W'(MAX_LAYERS));
  // sign bit dropped: only used when the height is not negative
  assign h_raw   = in_ch.height[ID_W-1:0];
  assign h_clamp = (CMP_W'(h_raw) > CMP_W'(count_r)) ? count_r : CNT_W'(h_raw);

  assign idx_inc   = idx_r + CNT_W'(1);
  assign idx_dec   = idx_r - CNT_W'(1);
  assign lid_m1    = stk_rd_id - ID_W'(1);
  assign list_last = (idx_inc == count_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_ch.req_type)
            REQ_NEW:  state_nxt = made_full ? S_RESP : S_POS;
            REQ_LIST: state_nxt = (count_r == '0) ? S_RESP : S_LIST;
            REQ_MOVE_ABS, REQ_MOVE_REL:
              state_nxt = id_bad ? S_RESP : S_POS;
            REQ_SET_HEIGHT, REQ_HIDE:
              state_nxt = id_bad ? S_RESP : S_FIND;
            default:  state_nxt = S_RESP;
          endcase
        end
      end
      S_POS: state_nxt = S_RESP;
      S_FIND: begin
        if (idx_r == count_r) begin
          state_nxt = (hide_r || count_full) ? S_RESP : S_INSERT;
        end else if (stk_hit) begin
          state_nxt = S_REMOVE;
        end
      end
      S_REMOVE: begin
        if (idx_inc >= count_r) begin
          state_nxt = hide_r ? S_RESP : S_INSERT;
        end
      end
      S_INSERT: begin
        if (idx_r <= h_r) begin
          state_nxt = S_RESP;
        end
      end
      S_LIST: begin
        if (slot_free && list_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_RESP: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and control outputs
  always_comb begin
    count_nxt      = count_r;
    made_nxt       = made_r;
    idx_nxt        = idx_r;
    h_nxt          = h_r;
    id_nxt         = id_r;
    hide_nxt       = hide_r;
    slot_nxt       = slot_r;
    pos_op_nxt     = pos_op_r;
    px_nxt         = px_r;
    py_nxt         = py_r;
    res_status_nxt = res_status_r;
    res_id_nxt     = res_id_r;
    res_zero_nxt   = res_zero_r;

    out_load       = 1'b0;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_x_nxt      = out_x_r;
    out_y_nxt      = out_y_r;
    out_idx_nxt    = out_idx_r;
    out_last_nxt   = out_last_r;

    stk_ctl.rd_idx = idx_r[IDX_W-1:0];
    stk_ctl.wr_en  = 1'b0;
    stk_ctl.wr_idx = idx_r[IDX_W-1:0];
    stk_ctl.wr_id  = stk_rd_id;
    stk_ctl.cmp_id = id_r;

    pos_ctl.op   = POS_NONE;
    pos_ctl.addr = slot_r;
    pos_ctl.dx   = px_r;
    pos_ctl.dy   = py_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          id_nxt         = in_ch.layer_id;
          hide_nxt       = (in_ch.req_type == REQ_HIDE) || in_ch.height[HGT_W-1];
          h_nxt          = h_clamp;
          px_nxt         = in_ch.pos_x;
          py_nxt         = in_ch.pos_y;
          idx_nxt        = '0;
          slot_nxt       = IDX_W'(in_ch.layer_id - ID_W'(1));
          res_status_nxt = ST_OK;
          res_id_nxt     = '0;
          res_zero_nxt   = 1'b1;
          pos_op_nxt     = POS_NONE;
          case (in_ch.req_type)
            REQ_NEW: begin
              if (made_full) begin
                res_status_nxt = ST_FULL;
              end else begin
                made_nxt     = made_r + CNT_W'(1);
                slot_nxt     = made_r[IDX_W-1:0];
                pos_op_nxt   = POS_ZERO;
                res_id_nxt   = ID_W'(made_r + CNT_W'(1));
                res_zero_nxt = 1'b0;
              end
            end
            REQ_LIST: begin
            end
            REQ_MOVE_ABS, REQ_MOVE_REL, REQ_SET_HEIGHT, REQ_HIDE: begin
              if (id_bad) begin
                res_status_nxt = ST_UNKNOWN;
              end else begin
                res_id_nxt   = in_ch.layer_id;
                res_zero_nxt = 1'b0;
                if (in_ch.req_type == REQ_MOVE_ABS) begin
                  pos_op_nxt = POS_LOAD;
                end else if (in_ch.req_type == REQ_MOVE_REL) begin
                  pos_op_nxt = POS_ADD;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_POS: begin
        pos_ctl.op = pos_op_r;
      end
      S_FIND: begin
        if (idx_r != count_r) begin
          if (stk_hit) begin
            // a shown layer asked for the count goes to the top after removal
            if (!hide_r && (h_r == count_r)) begin
              h_nxt = h_r - CNT_W'(1);
            end
          end else begin
            idx_nxt = idx_inc;
          end
        end
      end
      S_REMOVE: begin
        stk_ctl.rd_idx = idx_inc[IDX_W-1:0];
        if (idx_inc < count_r) begin
          stk_ctl.wr_en = 1'b1;
          idx_nxt       = idx_inc;
        end else begin
          count_nxt = count_r - CNT_W'(1);
          idx_nxt   = count_r - CNT_W'(1);
        end
      end
      S_INSERT: begin
        stk_ctl.rd_idx = idx_dec[IDX_W-1:0];
        stk_ctl.wr_en  = 1'b1;
        if (idx_r > h_r) begin
          idx_nxt = idx_dec;
        end else begin
          stk_ctl.wr_idx = h_r[IDX_W-1:0];
          stk_ctl.wr_id  = id_r;
          count_nxt      = count_r + CNT_W'(1);
        end
      end
      S_LIST: begin
        pos_ctl.addr = IDX_W'(lid_m1);
        if (slot_free) begin
          out_load       = 1'b1;
          out_status_nxt = ST_OK;
          out_id_nxt     = stk_rd_id;
          out_x_nxt      = pos_rd_x;
          out_y_nxt      = pos_rd_y;
          out_idx_nxt    = ID_W'(idx_r);
          out_last_nxt   = list_last;
          idx_nxt        = idx_inc;
        end
      end
      S_RESP: begin
        if (slot_free) begin
          out_load       = 1'b1;
          out_status_nxt = res_status_r;
          out_id_nxt     = res_id_r;
          out_x_nxt      = res_zero_r ? '0 : pos_rd_x;
          out_y_nxt      = res_zero_r ? '0 : pos_rd_y;
          out_idx_nxt    = ID_W'(count_r);
          out_last_nxt   = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_nxt = out_load | (out_valid_r & ~out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      made_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      made_r      <= made_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    h_r          <= h_nxt;
    id_r         <= id_nxt;
    hide_r       <= hide_nxt;
    slot_r       <= slot_nxt;
    pos_op_r     <= pos_op_nxt;
    px_r         <= px_nxt;
    py_r         <= py_nxt;
    res_status_r <= res_status_nxt;
    res_id_r     <= res_id_nxt;
    res_zero_r   <= res_zero_nxt;
    if (out_load) begin
      out_status_r <= out_status_nxt;
      out_id_r     <= out_id_nxt;
      out_x_r      <= out_x_nxt;
      out_y_r      <= out_y_nxt;
      out_idx_r    <= out_idx_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.out_layer_id = out_id_r;
  assign out_ch.out_x        = out_x_r;
  assign out_ch.out_y        = out_y_r;
  assign out_ch.stack_index  = out_idx_r;
  assign out_ch.last         = out_last_r;

endmodule
`default_nettype wire

/* rtl/core/lzot_chk.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lzot_chk
// Port-level checks of the layer z-order table, bound to the top level.
// ----------------------------------------------------------------------------
module lzot_chk (
  input wire                               clk,
  input wire                               rst_n,
  input wire                               in_valid,
  input wire                               in_ready,
  input wire                               out_valid,
  input wire                               out_ready,
  input wire [lzot_pkg::ST_W-1:0]          status,
  input wire [lzot_pkg::ID_W-1:0]          out_layer_id,
  input wire signed [lzot_pkg::POS_W-1:0]  out_x,
  input wire signed [lzot_pkg::POS_W-1:0]  out_y,
  input wire [lzot_pkg::ID_W-1:0]          stack_index,
  input wire                               last
);
  import lzot_pkg::*;

  // a stalled word holds its layer id, position, index and last flag
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_layer_id) &&
    $stable(out_x) && $stable(out_y) && $stable(stack_index) && $stable(last))
    else $error("result word changed while stalled");

  // one request at a time: ready drops right after acceptance
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  // rejected requests give a single word with no layer data
  a_reject_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != ST_OK |-> last && out_layer_id == '0)
    else $error("rejected request with payload or follow-on word");

  a_reject_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != ST_OK |-> out_x == '0 && out_y == '0)
    else $error("rejected request reports a position");

endmodule

bind layer_z_order_table_core lzot_chk u_lzot_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .status       (out_ch.status),
  .out_layer_id (out_ch.out_layer_id),
  .out_x        (out_ch.out_x),
  .out_y        (out_ch.out_y),
  .stack_index  (out_ch.stack_index),
  .last         (out_ch.last)
);
`default_nettype wire

/* tb/tb_layer_z_order_table_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_layer_z_order_table_core
// Drives layer requests into the table through the request channel and
// checks every result word against an in-bench copy of the layer table and
// z-order stack. A short table of directed requests covers the corner cases;
// random requests follow, mostly stack reordering with moves and listings.
// Both channels idle at random, with one stretch of full throughput.
// ----------------------------------------------------------------------------
module tb_layer_z_order_table_core;
  import lzot_pkg::*;

  localparam logic [REQ_W-1:0] REQ_SPARE_6 = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_7 = 3'd7;

  localparam int RANDOM_REQS = 84;
  localparam int IDLE_PCT    = 38;
  localparam int DRAIN_WAIT  = 64;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [REQ_W-1:0]        req;
    logic [ID_W-1:0]         id;
    logic signed [HGT_W-1:0] hgt;
    logic [POS_W-1:0]        x;
    logic [POS_W-1:0]        y;
  } req_word_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [ID_W-1:0]  id;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [ID_W-1:0]  idx;
    logic             last;
  } layer_word_t;

  typedef struct packed {
    req_word_t   cmd;
    logic [4:0]  rep;
    logic        typed;
    layer_word_t want;
  } dir_row_t;

  logic clk;
  logic rst_n;

  lzot_in_if  in_ch ();
  lzot_out_if out_ch ();

  layer_z_order_table_core dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Shadow copy of the layer table and stack
  logic [ID_W-1:0]  zstack [MAX_LAYERS];
  logic [POS_W-1:0] layer_x [MAX_LAYERS];
  logic [POS_W-1:0] layer_y [MAX_LAYERS];
  int               shown;
  int               made;

  layer_word_t pending_words[$];
  dir_row_t    directed_rows[$];
  layer_word_t head_word;
  int          mismatches = 0;
  int          cycles = 0;
  logic        no_idle;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_layer_z_order_table_core NOT OK");
      $finish;
    end
  end

  function automatic layer_word_t lw(logic [ST_W-1:0] st, int id, logic [POS_W-1:0] x,
                                     logic [POS_W-1:0] y, int idx, int last);
    layer_word_t w;
    w.status = st;
    w.id     = id[ID_W-1:0];
    w.x      = x;
    w.y      = y;
    w.idx    = idx[ID_W-1:0];
    w.last   = last[0];
    return w;
  endfunction

  function automatic int stack_pos(int id);
    for (int i = 0; i < shown; i++) begin
      if (zstack[i] == id) return i;
    end
    return shown;
  endfunction

  function automatic void stack_drop(int at);
    for (int i = at; i + 1 < shown; i++) zstack[i] = zstack[i + 1];
    shown--;
  endfunction

  function automatic void stack_put(int at, int id);
    if (shown >= MAX_LAYERS) return;
    for (int i = shown; i > at; i--) zstack[i] = zstack[i - 1];
    zstack[at] = id[ID_W-1:0];
    shown++;
  endfunction

  // Applies one request to the shadow table and queues the words it yields
  function automatic void layer_table_step(req_word_t w);
    int id;
    int slot;
    int h;
    int at;
    int lid;
    id = w.id;
    if (w.req == REQ_NEW) begin
      if (made >= MAX_LAYERS) begin
        pending_words.push_back(lw(ST_FULL, 0, '0, '0, shown, 1));
      end else begin
        made++;
        layer_x[made - 1] = '0;
        layer_y[made - 1] = '0;
        pending_words.push_back(lw(ST_OK, made, '0, '0, shown, 1));
      end
    end else if (w.req == REQ_LIST) begin
      if (shown == 0) begin
        pending_words.push_back(lw(ST_OK, 0, '0, '0, 0, 1));
      end else begin
        for (int i = 0; i < shown; i++) begin
          lid = zstack[i];
          pending_words.push_back(lw(ST_OK, lid, layer_x[lid - 1], layer_y[lid - 1],
                                     i, int'(i + 1 == shown)));
        end
      end
    end else if (w.req > REQ_LIST) begin
      pending_words.push_back(lw(ST_OK, 0, '0, '0, shown, 1));
    end else if (id == 0 || id > made) begin
      pending_words.push_back(lw(ST_UNKNOWN, 0, '0, '0, shown, 1));
    end else begin
      slot = id - 1;
      if (w.req == REQ_MOVE_ABS) begin
        layer_x[slot] = w.x;
        layer_y[slot] = w.y;
      end else if (w.req == REQ_MOVE_REL) begin
        layer_x[slot] = layer_x[slot] + w.x;
        layer_y[slot] = layer_y[slot] + w.y;
      end else if (w.req == REQ_HIDE || w.hgt[HGT_W-1]) begin
        at = stack_pos(id);
        if (at < shown) stack_drop(at);
      end else begin
        h = w.hgt;
        if (h > shown) h = shown;
        at = stack_pos(id);
        if (at >= shown) begin
          stack_put(h, id);
        end else begin
          // already shown: the top slot is one lower once it is pulled out
          if (h == shown) h--;
          stack_drop(at);
          stack_put(h, id);
        end
      end
      pending_words.push_back(lw(ST_OK, id, layer_x[slot], layer_y[slot], shown, 1));
    end
  endfunction

  task automatic issue_request(req_word_t w, logic typed, layer_word_t want);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.req_type <= w.req;
    in_ch.layer_id <= w.id;
    in_ch.height   <= w.hgt;
    in_ch.pos_x    <= w.x;
    in_ch.pos_y    <= w.y;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    layer_table_step(w);
    // hand-typed expectation replaces the predicted word
    if (typed) pending_words[pending_words.size() - 1] = want;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  function automatic void row(logic [REQ_W-1:0] req, int id, int hgt, int x, int y,
                              int rep, logic typed, layer_word_t want);
    dir_row_t r;
    r.cmd.req = req;
    r.cmd.id  = id[ID_W-1:0];
    r.cmd.hgt = hgt[HGT_W-1:0];
    r.cmd.x   = x[POS_W-1:0];
    r.cmd.y   = y[POS_W-1:0];
    r.rep     = rep[4:0];
    r.typed   = typed;
    r.want    = want;
    directed_rows.push_back(r);
  endfunction

  function automatic void field_check(string name, logic [POS_W-1:0] want,
                                      logic [POS_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_words.size() == 0) begin
          $error("out_layer_id: expected no word, got %0d", out_ch.out_layer_id);
          mismatches++;
        end else begin
          head_word = pending_words.pop_front();
          field_check("status", POS_W'(head_word.status), POS_W'(out_ch.status));
          field_check("out_layer_id", POS_W'(head_word.id), POS_W'(out_ch.out_layer_id));
          field_check("out_x", head_word.x, out_ch.out_x);
          field_check("out_y", head_word.y, out_ch.out_y);
          field_check("stack_index", POS_W'(head_word.idx), POS_W'(out_ch.stack_index));
          field_check("last", POS_W'(head_word.last), POS_W'(out_ch.last));
        end
      end
      out_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin
    req_word_t   w;
    layer_word_t none;
    int          pick;

    none = '0;
    for (int i = 0; i < MAX_LAYERS; i++) begin
      zstack[i]  = '0;
      layer_x[i] = '0;
      layer_y[i] = '0;
    end
    shown = 0;
    made  = 0;

    rst_n          <= 1'b0;
    no_idle        <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.req_type <= REQ_NEW;
    in_ch.layer_id <= '0;
    in_ch.height   <= '0;
    in_ch.pos_x    <= '0;
    in_ch.pos_y    <= '0;

    // empty table: listing, unknown ids, spare codes, allocation, full table
    row(REQ_LIST, 0, 0, 0, 0, 1, 1'b1, lw(ST_OK, 0, '0, '0, 0, 1));
    row(REQ_HIDE, 0, 0, 0, 0, 1, 1'b1, lw(ST_UNKNOWN, 0, '0, '0, 0, 1));
    row(REQ_MOVE_ABS, 1, 0, 5, 5, 1, 1'b1, lw(ST_UNKNOWN, 0, '0, '0, 0, 1));
    row(REQ_SPARE_6, 3, 7, 1, 1, 1, 1'b1, lw(ST_OK, 0, '0, '0, 0, 1));
    row(REQ_SPARE_7, 0, -1, -1, -1, 1, 1'b1, lw(ST_OK, 0, '0, '0, 0, 1));
    row(REQ_NEW, 0, 0, 0, 0, 1, 1'b1, lw(ST_OK, 1, '0, '0, 0, 1));
    row(REQ_NEW, 31, 31, -1, -1, 15, 1'b0, none);
    row(REQ_NEW, 0, 0, 0, 0, 1, 1'b1, lw(ST_FULL, 0, '0, '0, 0, 1));
    // position extremes and wrap on relative moves
    row(REQ_MOVE_ABS, 16, 0, -32768, 32767, 1, 1'b0, none);
    row(REQ_MOVE_ABS, 1, 0, 32767, -32768, 1, 1'b0, none);
    row(REQ_MOVE_REL, 1, 0, 1, -1, 1, 1'b0, none);
    // height clamp, bottom insert, top via count, shown layer to top, hide
    row(REQ_SET_HEIGHT, 1, 31, 0, 0, 1, 1'b0, none);
    row(REQ_SET_HEIGHT, 2, 0, 0, 0, 1, 1'b0, none);
    row(REQ_SET_HEIGHT, 16, 2, 0, 0, 1, 1'b0, none);
    row(REQ_SET_HEIGHT, 2, 3, 0, 0, 1, 1'b0, none);
    row(REQ_SET_HEIGHT, 16, -32, 0, 0, 1, 1'b0, none);
    row(REQ_HIDE, 16, 0, 0, 0, 1, 1'b0, none);
    row(REQ_SET_HEIGHT, 17, 1, 0, 0, 1, 1'b0, none);
    row(REQ_MOVE_ABS, 31, 0, 9, 9, 1, 1'b0, none);
    row(REQ_SET_HEIGHT, 0, 0, 0, 0, 1, 1'b0, none);
    row(REQ_LIST, 0, 0, 0, 0, 1, 1'b0, none);
    row(REQ_SET_HEIGHT, 1, 1, 0, 0, 1, 1'b0, none);
    row(REQ_LIST, 0, 0, 0, 0, 1, 1'b0, none);
    row(REQ_HIDE, 1, 0, 0, 0, 1, 1'b0, none);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      for (int k = 0; k < directed_rows[r].rep; k++) begin
        issue_request(directed_rows[r].cmd, directed_rows[r].typed, directed_rows[r].want);
      end
    end
    wait_drained();

    for (int n = 0; n < RANDOM_REQS; n++) begin
      no_idle <= (n >= 40 && n < 75);
      if (n == 80) wait_drained();
      pick  = $urandom_range(99);
      w.x   = POS_W'($urandom);
      w.y   = POS_W'($urandom);
      w.hgt = HGT_W'($urandom_range(0, 63));
      w.id  = ($urandom_range(99) < 85) ? ID_W'($urandom_range(1, MAX_LAYERS))
                                        : ID_W'($urandom_range(0, 31));
      if (pick < 5) begin
        w.req = REQ_NEW;
      end else if (pick < 40) begin
        w.req = REQ_SET_HEIGHT;
        if ($urandom_range(99) < 80) w.hgt = HGT_W'($urandom_range(0, shown + 1));
      end else if (pick < 48) begin
        w.req = REQ_HIDE;
      end else if (pick < 62) begin
        w.req = REQ_MOVE_ABS;
      end else if (pick < 74) begin
        w.req = REQ_MOVE_REL;
      end else if (pick < 90) begin
        w.req = REQ_LIST;
      end else if (pick < 95) begin
        w.req = ($urandom_range(1) != 0) ? REQ_SPARE_7 : REQ_SPARE_6;
      end else begin
        w.req = REQ_W'($urandom_range(0, 7));
      end
      issue_request(w, 1'b0, none);
    end

    in_ch.valid <= 1'b0;
    no_idle     <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatches == 0) begin
      $display("tb_layer_z_order_table_core OK");
    end else begin
      $display("tb_layer_z_order_table_core NOT OK");
    end
    $finish;
  end

endmodule
